>>> hdl/qec_pkg.sv
// Package with widths, constants and helpers of the quadrature encoder counter.
package qec_pkg;

   localparam int CSR_INDEX_WIDTH = 4;
   localparam int CSR_DATA_WIDTH  = 16;
   localparam int REPORT_WIDTH    = 16;
   localparam int POSITION_WIDTH  = 3;

   typedef logic [CSR_INDEX_WIDTH-1:0] csr_index_type;
   typedef logic [CSR_DATA_WIDTH-1:0]  csr_data_type;
   typedef logic [POSITION_WIDTH-1:0]  position_type;
   typedef logic [1:0]                 phase_type;

   localparam csr_index_type CSR_SAMPLE_INTERVAL = csr_index_type'(0);
   localparam csr_index_type CSR_REPORT_DELAY    = csr_index_type'(1);

   localparam csr_data_type SAMPLE_INTERVAL_RESET = csr_data_type'(1);
   localparam csr_data_type REPORT_DELAY_RESET    = csr_data_type'(100);

   localparam position_type POS_INIT = position_type'(0);
   localparam position_type POS_ONE  = position_type'(1);
   localparam position_type POS_TWO  = position_type'(2);
   localparam position_type POS_THREE = position_type'(3);
   localparam position_type POS_FOUR = position_type'(4);

   localparam phase_type PHASE_00 = 2'b00;
   localparam phase_type PHASE_01 = 2'b01;
   localparam phase_type PHASE_11 = 2'b11;
   localparam phase_type PHASE_10 = 2'b10;

   localparam logic [1:0] STEP_FORWARD  = 2'd1;
   localparam logic [1:0] STEP_BACKWARD = 2'd3;

   function automatic position_type code_to_position(input phase_type code);
      position_type pos;
      case (code)
         PHASE_00: pos = POS_ONE;
         PHASE_01: pos = POS_TWO;
         PHASE_11: pos = POS_THREE;
         default:  pos = POS_FOUR;
      endcase
      return pos;
   endfunction

endpackage

>>> hdl/qec_req_if.sv
// Input channel: one tick item with key level and encoder phases.
interface qec_req_if;
   logic valid;
   logic ready;
   logic key_level;
   logic phase_a;
   logic phase_b;

   modport source (output valid, output key_level, output phase_a, output phase_b,
                   input ready);
   modport sink (input valid, input key_level, input phase_a, input phase_b,
                 output ready);
endinterface

>>> hdl/qec_rsp_if.sv
// Result channel: one report item per tick.
interface qec_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic                                 report_valid;
   logic                                 report_key;
   logic signed [qec_pkg::REPORT_WIDTH-1:0] report_count;
   qec_pkg::position_type                position;

   modport source (output valid, output report_valid, output report_key,
                   output report_count, output position, input ready);
   modport sink (input valid, input report_valid, input report_key,
                 input report_count, input position, output ready);
endinterface

>>> hdl/qec_csr_if.sv
// Configuration write channel: register index and write data.
interface qec_csr_if;
   logic                   valid;
   logic                   ready;
   qec_pkg::csr_index_type index;
   qec_pkg::csr_data_type  data;

   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

>>> hdl/quadrature_encoder_counter.sv
// Top level of the quadrature encoder counter with periodic step reports.
//
// Every accepted tick item yields exactly one result item in the next cycle; a new
// tick is taken every cycle while the result register is empty or being read, so
// the sustained rate is one item per cycle. The whole update (tick compare, x4
// position step, saturating count, report compare) sits between the input
// handshake and the result register. Configuration writes are always accepted;
// write them only while no tick is in flight.
module quadrature_encoder_counter #(
   parameter int TIME_WIDTH  = 32,
   parameter int COUNT_WIDTH = 16
) (
   input  logic      clock,
   input  logic      reset,
   qec_req_if.sink   req_chan,
   qec_rsp_if.source rsp_chan,
   qec_csr_if.sink   csr_chan
);

   localparam logic signed [COUNT_WIDTH-1:0] COUNT_MAX = {1'b0, {(COUNT_WIDTH-1){1'b1}}};
   localparam logic signed [COUNT_WIDTH-1:0] COUNT_MIN = {1'b1, {(COUNT_WIDTH-1){1'b0}}};

   qec_pkg::csr_data_type          sample_interval_ff;
   qec_pkg::csr_data_type          report_delay_ff;
   logic [TIME_WIDTH-1:0]          tick_ff, tick_in;
   logic [TIME_WIDTH-1:0]          last_sample_ff, last_sample_in;
   logic [TIME_WIDTH-1:0]          last_report_ff, last_report_in;
   logic                           held_key_ff, held_key_in;
   qec_pkg::phase_type             held_phase_ff, held_phase_in;
   logic                           phase_seen_ff, phase_seen_in;
   qec_pkg::position_type          pos_ff, pos_in;
   logic signed [COUNT_WIDTH-1:0]  count_ff, count_in;

   logic                                    rsp_valid_ff;
   logic                                    rsp_report_valid_ff, rsp_report_valid_in;
   logic                                    rsp_report_key_ff, rsp_report_key_in;
   logic signed [qec_pkg::REPORT_WIDTH-1:0] rsp_report_count_ff, rsp_report_count_in;

   logic                          req_fire;
   logic                          sample_due;
   logic                          report_due;
   logic                          moved;
   qec_pkg::phase_type            code;
   qec_pkg::position_type         target;
   logic [1:0]                    step_dir;
   logic signed [COUNT_WIDTH-1:0] count_key;
   logic signed [COUNT_WIDTH-1:0] count_step;
   logic signed [31:0]            count_wide;

   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign req_fire       = req_chan.valid && req_chan.ready;
   assign csr_chan.ready = 1'b1;

   assign code     = {req_chan.phase_a, req_chan.phase_b};
   assign target   = qec_pkg::code_to_position(code);
   assign tick_in  = tick_ff + TIME_WIDTH'(1);
   assign step_dir = target[1:0] - pos_ff[1:0];

   assign sample_due = (tick_in - last_sample_ff) >= TIME_WIDTH'(sample_interval_ff);
   assign report_due = (tick_in - last_report_ff) >= TIME_WIDTH'(report_delay_ff);
   assign moved      = sample_due && (!phase_seen_ff || code != held_phase_ff);

   always_comb begin
      last_sample_in = last_sample_ff;
      held_key_in    = held_key_ff;
      held_phase_in  = held_phase_ff;
      phase_seen_in  = phase_seen_ff;
      count_key      = count_ff;
      if (sample_due) begin
         last_sample_in = tick_in;
         if (req_chan.key_level != held_key_ff) begin
            held_key_in = req_chan.key_level;
            count_key   = '0;
         end
         if (moved) begin
            phase_seen_in = 1'b1;
            held_phase_in = code;
         end
      end
   end

   always_comb begin
      pos_in     = pos_ff;
      count_step = count_key;
      if (pos_ff == qec_pkg::POS_INIT) begin
         count_step = '0;
         if (moved) begin
            pos_in = target;
         end
      end else if (moved) begin
         pos_in = target;
         case (step_dir)
            qec_pkg::STEP_FORWARD: begin
               if (count_key != COUNT_MAX) begin
                  count_step = count_key + COUNT_WIDTH'(1);
               end
            end
            qec_pkg::STEP_BACKWARD: begin
               if (count_key != COUNT_MIN) begin
                  count_step = count_key - COUNT_WIDTH'(1);
               end
            end
            default: count_step = count_key;
         endcase
      end
   end

   assign count_wide = 32'(count_step);

   always_comb begin
      last_report_in      = last_report_ff;
      count_in            = count_step;
      rsp_report_valid_in = 1'b0;
      rsp_report_key_in   = 1'b0;
      rsp_report_count_in = '0;
      if (report_due) begin
         count_in = '0;
         if (count_step != '0) begin
            last_report_in      = tick_in;
            rsp_report_valid_in = 1'b1;
            rsp_report_key_in   = held_key_in;
            rsp_report_count_in = count_wide[qec_pkg::REPORT_WIDTH-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sample_interval_ff <= qec_pkg::SAMPLE_INTERVAL_RESET;
         report_delay_ff    <= qec_pkg::REPORT_DELAY_RESET;
         tick_ff            <= '0;
         last_sample_ff     <= '0;
         last_report_ff     <= '0;
         held_key_ff        <= 1'b0;
         held_phase_ff      <= '0;
         phase_seen_ff      <= 1'b0;
         pos_ff             <= qec_pkg::POS_INIT;
         count_ff           <= '0;
         rsp_valid_ff       <= 1'b0;
      end else begin
         if (csr_chan.valid) begin
            case (csr_chan.index)
               qec_pkg::CSR_SAMPLE_INTERVAL: sample_interval_ff <= csr_chan.data;
               qec_pkg::CSR_REPORT_DELAY:    report_delay_ff    <= csr_chan.data;
               default: ;
            endcase
         end
         if (req_fire) begin
            tick_ff        <= tick_in;
            last_sample_ff <= last_sample_in;
            last_report_ff <= last_report_in;
            held_key_ff    <= held_key_in;
            held_phase_ff  <= held_phase_in;
            phase_seen_ff  <= phase_seen_in;
            pos_ff         <= pos_in;
            count_ff       <= count_in;
            rsp_valid_ff   <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff   <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         rsp_report_valid_ff <= rsp_report_valid_in;
         rsp_report_key_ff   <= rsp_report_key_in;
         rsp_report_count_ff <= rsp_report_count_in;
      end
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.report_valid = rsp_report_valid_ff;
   assign rsp_chan.report_key   = rsp_report_key_ff;
   assign rsp_chan.report_count = rsp_report_count_ff;
   assign rsp_chan.position     = pos_ff;

   a_fire_gives_result: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> rsp_valid_ff)
      else $error("accepted item produced no result");

   a_report_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_report_valid_ff |-> rsp_report_count_ff != '0)
      else $error("report with zero count");

   a_quiet_result_clear: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_report_valid_ff |->
         rsp_report_count_ff == '0 && !rsp_report_key_ff)
      else $error("idle result carries data");

   a_init_count_zero: assert property (@(posedge clock) disable iff (reset)
      pos_ff == qec_pkg::POS_INIT |-> count_ff == '0)
      else $error("count nonzero in init state");

   a_position_range: assert property (@(posedge clock) disable iff (reset)
      pos_ff <= qec_pkg::POS_FOUR)
      else $error("position out of range");

endmodule
